/* src/shs_pkg.sv */
`timescale 1ns / 1ps

package shs_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS        = 1;
   localparam int UPC_BITS              = 4;
   localparam int DEGREES_PER_TURN      = 360;

   // floor(x / 360) = floor((x >> 3) * RECIP_45 / 2**RECIP_SHIFT) for x below 2**31
   localparam int          RECIP_SHIFT = 34;
   localparam logic [28:0] RECIP_45    = 29'd381774871;

   // commands
   localparam logic [2:0] CMD_RUN        = 3'd0;
   localparam logic [2:0] CMD_SET_DIR    = 3'd1;
   localparam logic [2:0] CMD_SET_STEPS  = 3'd2;
   localparam logic [2:0] CMD_SET_ANGLE  = 3'd3;
   localparam logic [2:0] CMD_RETURN     = 3'd4;
   localparam logic [2:0] CMD_REWIND     = 3'd5;
   localparam logic [2:0] CMD_SET_ORIGIN = 3'd6;

   // directions
   localparam logic [1:0] DIR_CW   = 2'd0;
   localparam logic [1:0] DIR_CCW  = 2'd1;
   localparam logic [1:0] DIR_STOP = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEPS_PER_TURN = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_HOLD     = 1'd1;

   // datapath operations
   localparam logic [3:0] OP_NOP        = 4'd0;
   localparam logic [3:0] OP_RUN_UPD    = 4'd1;
   localparam logic [3:0] OP_EMIT       = 4'd2;
   localparam logic [3:0] OP_SET_DIR    = 4'd3;
   localparam logic [3:0] OP_SET_STEPS  = 4'd4;
   localparam logic [3:0] OP_MUL        = 4'd5;
   localparam logic [3:0] OP_DIV_ANGLE  = 4'd6;
   localparam logic [3:0] OP_DIV_POS    = 4'd7;
   localparam logic [3:0] OP_DIV_STEP   = 4'd8;
   localparam logic [3:0] OP_ANGLE_WB   = 4'd9;
   localparam logic [3:0] OP_AIM_REM    = 4'd10;
   localparam logic [3:0] OP_AIM_ABS    = 4'd11;
   localparam logic [3:0] OP_ORIGIN     = 4'd12;
   localparam logic [3:0] OP_RECIP_360  = 4'd13;

   // sequencing conditions
   localparam logic [2:0] CJ_NEXT       = 3'd0;
   localparam logic [2:0] CJ_JUMP       = 3'd1;
   localparam logic [2:0] CJ_DISPATCH   = 3'd2;
   localparam logic [2:0] CJ_ANGLE_ZERO = 3'd3;
   localparam logic [2:0] CJ_SPT_ZERO   = 3'd4;
   localparam logic [2:0] CJ_DIV_DONE   = 3'd5;
   localparam logic [2:0] CJ_EMIT_DONE  = 3'd6;

   // microcode addresses
   localparam logic [UPC_BITS-1:0] UA_FETCH     = 4'd0;
   localparam logic [UPC_BITS-1:0] UA_RUN       = 4'd1;
   localparam logic [UPC_BITS-1:0] UA_EMIT      = 4'd2;
   localparam logic [UPC_BITS-1:0] UA_SET_DIR   = 4'd3;
   localparam logic [UPC_BITS-1:0] UA_SET_STEPS = 4'd4;
   localparam logic [UPC_BITS-1:0] UA_ANGLE     = 4'd5;
   localparam logic [UPC_BITS-1:0] UA_MUL       = 4'd6;
   localparam logic [UPC_BITS-1:0] UA_DIV_A     = 4'd7;
   localparam logic [UPC_BITS-1:0] UA_RECIP_A   = 4'd8;
   localparam logic [UPC_BITS-1:0] UA_ANGLE_WB  = 4'd9;
   localparam logic [UPC_BITS-1:0] UA_RETURN    = 4'd10;
   localparam logic [UPC_BITS-1:0] UA_DIV_P     = 4'd11;
   localparam logic [UPC_BITS-1:0] UA_STEP_P    = 4'd12;
   localparam logic [UPC_BITS-1:0] UA_AIM_REM   = 4'd13;
   localparam logic [UPC_BITS-1:0] UA_REWIND    = 4'd14;
   localparam logic [UPC_BITS-1:0] UA_ORIGIN    = 4'd15;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [1:0]         direction;
      logic signed [31:0] step_count;
      logic signed [15:0] angle_deg;
   } req_type;

   typedef struct packed {
      logic [3:0]         coils;
      logic [15:0]        hold_ms;
      logic signed [31:0] position;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]          op;
      logic [2:0]          cond;
      logic [UPC_BITS-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [UPC_BITS-1:0] addr);
      ucode_type w;
      begin
         unique case (addr)
            UA_FETCH:     w = '{OP_NOP,       CJ_DISPATCH,   UA_FETCH};
            UA_RUN:       w = '{OP_RUN_UPD,   CJ_NEXT,       UA_FETCH};
            UA_EMIT:      w = '{OP_EMIT,      CJ_EMIT_DONE,  UA_FETCH};
            UA_SET_DIR:   w = '{OP_SET_DIR,   CJ_JUMP,       UA_FETCH};
            UA_SET_STEPS: w = '{OP_SET_STEPS, CJ_JUMP,       UA_FETCH};
            UA_ANGLE:     w = '{OP_NOP,       CJ_ANGLE_ZERO, UA_FETCH};
            UA_MUL:       w = '{OP_MUL,       CJ_NEXT,       UA_FETCH};
            UA_DIV_A:     w = '{OP_DIV_ANGLE, CJ_NEXT,       UA_FETCH};
            UA_RECIP_A:   w = '{OP_RECIP_360, CJ_NEXT,       UA_FETCH};
            UA_ANGLE_WB:  w = '{OP_ANGLE_WB,  CJ_JUMP,       UA_FETCH};
            UA_RETURN:    w = '{OP_NOP,       CJ_SPT_ZERO,   UA_REWIND};
            UA_DIV_P:     w = '{OP_DIV_POS,   CJ_NEXT,       UA_FETCH};
            UA_STEP_P:    w = '{OP_DIV_STEP,  CJ_DIV_DONE,   UA_FETCH};
            UA_AIM_REM:   w = '{OP_AIM_REM,   CJ_JUMP,       UA_FETCH};
            UA_REWIND:    w = '{OP_AIM_ABS,   CJ_JUMP,       UA_FETCH};
            UA_ORIGIN:    w = '{OP_ORIGIN,    CJ_JUMP,       UA_FETCH};
            default:      w = '{OP_NOP,       CJ_JUMP,       UA_FETCH};
         endcase
         return w;
      end
   endfunction

   function automatic logic [UPC_BITS-1:0] cmd_entry(input logic [2:0] cmd);
      logic [UPC_BITS-1:0] a;
      begin
         unique case (cmd)
            CMD_RUN:        a = UA_RUN;
            CMD_SET_DIR:    a = UA_SET_DIR;
            CMD_SET_STEPS:  a = UA_SET_STEPS;
            CMD_SET_ANGLE:  a = UA_ANGLE;
            CMD_RETURN:     a = UA_RETURN;
            CMD_REWIND:     a = UA_REWIND;
            CMD_SET_ORIGIN: a = UA_ORIGIN;
            default:        a = UA_FETCH;
         endcase
         return a;
      end
   endfunction

   // half-step coil patterns
   function automatic logic [3:0] coil_pattern(input logic ccw, input logic [2:0] phase);
      logic [3:0] p;
      logic [2:0] k;
      begin
         k = ccw ? 3'(3'd7 - phase) : phase;
         case (k)
            3'd0:    p = 4'h9;
            3'd1:    p = 4'h1;
            3'd2:    p = 4'h3;
            3'd3:    p = 4'h2;
            3'd4:    p = 4'h6;
            3'd5:    p = 4'h4;
            3'd6:    p = 4'hC;
            default: p = 4'h8;
         endcase
         return p;
      end
   endfunction

endpackage

/* src/stepper_half_step_sequencer.sv */
`timescale 1ns / 1ps
// channel | direction | payload              | accepted when
// req     | in        | cmd, direction, ...  | req_valid && req_ready
// rsp     | out       | coils, hold_ms, ...  | rsp_valid && rsp_ready
// csr     | in        | index, data          | csr_valid (always ready)
// A command is taken only at the fetch step.
// Run: 8 drive patterns or 1 all-off pattern; output stalls hold the emit step.
// Set angle: skipped for a zero angle. Return: serial remainder by the turn length,
// or rewind with a zero turn length. Unused code: back to fetch.
// Reset is synchronous, with no clearing pass. A held rsp_ready stalls
// the emit step; the last pattern waits in the output register.

module stepper_half_step_sequencer #(
   parameter int POSITION_BITS = shs_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  shs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output shs_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [shs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [15:0]                         csr_data
);
   import shs_pkg::*;

   localparam int DIV_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   // control
   logic [UPC_BITS-1:0] upc_ff, upc_in;
   ucode_type           cw;
   logic                emit_fire;

   // architectural state
   logic [15:0]              spt_ff, spt_in;
   logic [15:0]              hold_ff, hold_in;
   logic [1:0]               dir_ff, dir_in;
   logic [31:0]              target_ff, target_in;
   logic [31:0]              done_ff, done_in;
   logic                     halted_ff, halted_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   // datapath registers
   req_type              item_ff, item_in;
   logic                 drive_ff, drive_in;
   logic                 ccw_ff, ccw_in;
   logic [2:0]           phase_ff, phase_in;
   logic signed [32:0]   prod_ff, prod_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [16:0]          rem_ff, rem_in;
   logic [15:0]          den_ff, den_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // helpers
   logic                     pos_neg;
   logic [POSITION_BITS-1:0] pos_mag;
   logic signed [63:0]       pos_wide;
   logic [31:0]              pos_out;
   logic                     moving;
   logic [31:0]              done_next;
   logic signed [32:0]       ang_ext, spt_ext;
   logic [31:0]              prod_mag;
   logic [16:0]              div_trial;
   logic [16:0]              div_diff;
   logic [31:0]              quo_low;
   logic [57:0]              recip_prod;

   assign cw        = ucode_rom(upc_ff);
   assign req_ready = (upc_ff == UA_FETCH);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos_neg  = pos_ff[POSITION_BITS-1];
   assign pos_mag  = pos_neg ? POSITION_BITS'(-pos_ff) : pos_ff;
   assign pos_wide = 64'($signed(pos_ff));
   assign pos_out  = pos_wide[31:0];
   assign moving   = !halted_ff && (dir_ff == DIR_CW || dir_ff == DIR_CCW);
   assign done_next = (target_ff != 32'd0 && $signed(done_ff) < $signed(target_ff))
                      ? 32'(done_ff + 32'd1) : done_ff;
   assign ang_ext  = 33'(item_ff.angle_deg);
   assign spt_ext  = $signed(33'({1'b0, spt_ff}));
   assign prod_mag = prod_ff[32] ? 32'(-prod_ff) : prod_ff[31:0];
   assign div_trial = {rem_ff[15:0], quo_ff[DIV_BITS-1]};
   assign div_diff  = 17'(div_trial - {1'b0, den_ff});
   assign quo_low   = quo_ff[31:0];
   // 360 = 8 * 45: drop three bits, then multiply by the reciprocal of 45
   assign recip_prod = 58'(quo_low[31:3]) * 58'(RECIP_45);
   assign emit_fire = (cw.op == OP_EMIT) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      upc_in = upc_ff;
      case (cw.cond)
         CJ_NEXT:       upc_in = UPC_BITS'(upc_ff + 1'b1);
         CJ_JUMP:       upc_in = cw.target;
         CJ_DISPATCH: begin
            if (req_valid) upc_in = cmd_entry(req_data.cmd);
         end
         CJ_ANGLE_ZERO: upc_in = (item_ff.angle_deg == 16'sd0) ? cw.target
                                                               : UPC_BITS'(upc_ff + 1'b1);
         CJ_SPT_ZERO:   upc_in = (spt_ff == 16'd0) ? cw.target : UPC_BITS'(upc_ff + 1'b1);
         CJ_DIV_DONE: begin
            if (cnt_ff == CNT_BITS'(1)) upc_in = UPC_BITS'(upc_ff + 1'b1);
         end
         CJ_EMIT_DONE: begin
            if (emit_fire && (!drive_ff || phase_ff == 3'd7)) upc_in = cw.target;
         end
         default:       upc_in = UA_FETCH;
      endcase
   end

   // datapath
   always_comb begin
      spt_in       = spt_ff;
      hold_in      = hold_ff;
      dir_in       = dir_ff;
      target_in    = target_ff;
      done_in      = done_ff;
      halted_in    = halted_ff;
      pos_in       = pos_ff;
      item_in      = item_ff;
      drive_in     = drive_ff;
      ccw_in       = ccw_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEPS_PER_TURN: spt_in  = csr_data;
            CSR_PHASE_HOLD:     hold_in = csr_data;
            default:            ;
         endcase
      end

      if (req_valid && req_ready) item_in = req_data;

      unique case (cw.op) inside
         OP_NOP: ;
         OP_RUN_UPD: begin
            drive_in = moving;
            ccw_in   = (dir_ff == DIR_CCW);
            phase_in = 3'd0;
            if (moving) begin
               pos_in = (dir_ff == DIR_CCW) ? POSITION_BITS'(pos_ff - 1'b1)
                                            : POSITION_BITS'(pos_ff + 1'b1);
            end
            done_in = done_next;
            if (target_ff != 32'd0 && $signed(done_next) >= $signed(target_ff))
               halted_in = 1'b1;
         end
         OP_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in     = 1'b1;
               rsp_in.coils     = drive_ff ? coil_pattern(ccw_ff, phase_ff) : 4'h0;
               rsp_in.hold_ms   = drive_ff ? hold_ff : 16'd0;
               rsp_in.position  = $signed(pos_out);
               rsp_in.last      = !drive_ff || phase_ff == 3'd7;
               phase_in         = 3'(phase_ff + 1'b1);
            end
         end
         OP_SET_DIR: begin
            dir_in = (item_ff.direction > DIR_STOP) ? DIR_STOP : item_ff.direction;
         end
         OP_SET_STEPS: begin
            target_in = item_ff.step_count;
            done_in   = 32'd0;
            halted_in = 1'b0;
         end
         OP_MUL: prod_in = ang_ext * spt_ext;
         OP_DIV_ANGLE: quo_in = DIV_BITS'(prod_mag);
         OP_RECIP_360: quo_in = DIV_BITS'(recip_prod[57:RECIP_SHIFT]);
         OP_DIV_POS: begin
            quo_in = DIV_BITS'(pos_mag);
            rem_in = 17'd0;
            den_in = spt_ff;
            cnt_in = CNT_BITS'(DIV_BITS);
         end
         OP_DIV_STEP: begin
            // restoring division, one quotient bit per cycle
            if (div_trial >= {1'b0, den_ff}) begin
               rem_in = div_diff;
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = div_trial;
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
            end
            cnt_in = CNT_BITS'(cnt_ff - 1'b1);
         end
         OP_ANGLE_WB: begin
            target_in = prod_ff[32] ? 32'(-quo_low) : quo_low;
            done_in   = 32'd0;
            halted_in = 1'b0;
         end
         OP_AIM_REM, OP_AIM_ABS: begin
            if (pos_ff == '0)  dir_in = DIR_STOP;
            else if (pos_neg)  dir_in = DIR_CW;
            else               dir_in = DIR_CCW;
            if (cw.op == OP_AIM_REM) target_in = 32'({16'd0, rem_ff[15:0]} - 32'd1);
            else                     target_in = 32'(DIV_BITS'(pos_mag) - 1'b1);
            done_in   = 32'd0;
            halted_in = 1'b0;
         end
         OP_ORIGIN: pos_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UA_FETCH;
         spt_ff       <= 16'd512;
         hold_ff      <= 16'd1;
         dir_ff       <= DIR_CW;
         target_ff    <= 32'd0;
         done_ff      <= 32'd0;
         halted_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         spt_ff       <= spt_in;
         hold_ff      <= hold_in;
         dir_ff       <= dir_in;
         target_ff    <= target_in;
         done_ff      <= done_in;
         halted_ff    <= halted_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      drive_ff <= drive_in;
      ccw_ff   <= ccw_in;
      phase_ff <= phase_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import shs_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 60;
   localparam int STUCK_LIMIT     = 3000;
   localparam int ITEMS_PER_PHASE = 83;
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   // clockwise half-step order, step k in bits [4k+3:4k]
   localparam logic [31:0] CW_COILS = 32'h8C462319;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0]               csr_data  = '0;

   // motor state as the block should hold it
   logic [15:0] turn_len     = 16'd512;
   logic [15:0] hold_len     = 16'd1;
   logic [1:0]  drive_dir    = DIR_CW;
   logic [31:0] step_target  = '0;
   logic [31:0] step_done    = '0;
   logic        motor_halted = 1'b0;
   logic [31:0] shaft_pos    = '0;

   req_type cmd_backlog[$];
   rsp_type expected_patterns[$];

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic req_taken      = 1'b0;
   bit   hold_off_arm   = 1'b0;
   bit   hold_off_done  = 1'b0;
   int   hold_off_count = 0;
   int   error_count    = 0;
   int   stuck_cycles   = 0;

   stepper_half_step_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic predict_patterns(input req_type r);
      rsp_type     p;
      logic [31:0] mag;
      longint      prod;
      longint      span;
      bit          moving;
      begin
         case (r.cmd) inside
            CMD_RUN: begin
               moving = !motor_halted && (drive_dir == DIR_CW || drive_dir == DIR_CCW);
               if (moving) begin
                  shaft_pos = (drive_dir == DIR_CW) ? shaft_pos + 32'd1 : shaft_pos - 32'd1;
                  for (int k = 0; k < 8; k++) begin
                     p.coils    = CW_COILS[4 * ((drive_dir == DIR_CW) ? k : 7 - k) +: 4];
                     p.hold_ms  = hold_len;
                     p.position = shaft_pos;
                     p.last     = (k == 7);
                     expected_patterns.push_back(p);
                  end
               end else begin
                  p.coils    = 4'h0;
                  p.hold_ms  = 16'h0;
                  p.position = shaft_pos;
                  p.last     = 1'b1;
                  expected_patterns.push_back(p);
               end
               if (step_target != 0 && $signed(step_done) < $signed(step_target))
                  step_done = step_done + 32'd1;
               if (step_target != 0 && $signed(step_done) >= $signed(step_target))
                  motor_halted = 1'b1;
            end
            CMD_SET_DIR: begin
               // code three is kept as stop
               drive_dir = (r.direction > DIR_STOP) ? DIR_STOP : r.direction;
            end
            CMD_SET_STEPS: begin
               step_target  = r.step_count;
               step_done    = '0;
               motor_halted = 1'b0;
            end
            CMD_SET_ANGLE: begin
               if (r.angle_deg != 0) begin
                  prod         = $signed(r.angle_deg);
                  span         = turn_len;
                  prod         = prod * span / DEGREES_PER_TURN;
                  step_target  = prod[31:0];
                  step_done    = '0;
                  motor_halted = 1'b0;
               end
            end
            CMD_RETURN, CMD_REWIND: begin
               if (shaft_pos == 0)
                  drive_dir = DIR_STOP;
               else if (shaft_pos[31])
                  drive_dir = DIR_CW;
               else
                  drive_dir = DIR_CCW;
               mag = shaft_pos[31] ? 32'd0 - shaft_pos : shaft_pos;
               // zero turn length makes return behave like rewind
               if (r.cmd == CMD_RETURN && turn_len != 0)
                  mag = mag % turn_len;
               step_target  = mag - 32'd1;
               step_done    = '0;
               motor_halted = 1'b0;
            end
            CMD_SET_ORIGIN: shaft_pos = '0;
            default: ;
         endcase
      end
   endtask

   // monitor: config, predictions and checks, all at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         turn_len     = 16'd512;
         hold_len     = 16'd1;
         drive_dir    = DIR_CW;
         step_target  = '0;
         step_done    = '0;
         motor_halted = 1'b0;
         shaft_pos    = '0;
         req_taken    <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_STEPS_PER_TURN)
               turn_len = csr_data;
            else if (csr_index == CSR_PHASE_HOLD)
               hold_len = csr_data;
         end
         if (req_valid && req_ready)
            predict_patterns(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_patterns.size() == 0) begin
               $display("%0t: unexpected transfer coils=%h hold=%0d pos=%0d last=%b", $time,
                        rsp_data.coils, rsp_data.hold_ms, rsp_data.position, rsp_data.last);
               error_count++;
            end else begin
               want = expected_patterns.pop_front();
               if (rsp_data.coils !== want.coils || rsp_data.hold_ms !== want.hold_ms ||
                   rsp_data.position !== want.position || rsp_data.last !== want.last) begin
                  $display("%0t: mismatch exp coils=%h hold=%0d pos=%0d last=%b", $time,
                           want.coils, want.hold_ms, want.position, want.last);
                  $display("%0t:          got coils=%h hold=%0d pos=%0d last=%b", $time,
                           rsp_data.coils, rsp_data.hold_ms, rsp_data.position,
                           rsp_data.last);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // command driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_taken || !req_valid) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= cmd_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // pattern receiver, with one long hold-off when armed
   always @(negedge clock) begin
      if (hold_off_arm && !hold_off_done) begin
         rsp_ready <= 1'b0;
         hold_off_count++;
         if (hold_off_count == HOLD_OFF_CYCLES)
            hold_off_done <= 1'b1;
      end else begin
         rsp_ready <= !reset && $urandom_range(99) >= recv_stall_pct;
      end
   end

   task automatic queue_req(input logic [2:0] c, input logic [1:0] d,
                            input logic [31:0] n, input logic [15:0] a);
      req_type r;
      begin
         r.cmd        = c;
         r.direction  = d;
         r.step_count = n;
         r.angle_deg  = a;
         cmd_backlog.push_back(r);
      end
   endtask

   function automatic req_type random_req();
      req_type r;
      int      pick;
      begin
         pick         = $urandom_range(99);
         r.direction  = 2'($urandom);
         r.step_count = $urandom;
         r.angle_deg  = 16'($urandom);
         if (pick < 55) begin
            r.cmd = CMD_RUN;
         end else if (pick < 67) begin
            r.cmd = CMD_SET_DIR;
            if ($urandom_range(3) != 0)
               r.direction = 2'($urandom_range(1));
         end else if (pick < 77) begin
            r.cmd = CMD_SET_STEPS;
            if ($urandom_range(4) != 0)
               r.step_count = $urandom_range(12);
         end else if (pick < 85) begin
            r.cmd = CMD_SET_ANGLE;
            if ($urandom_range(4) != 0)
               r.angle_deg = 16'($urandom_range(60)) - 16'd30;
         end else if (pick < 91) begin
            r.cmd = CMD_RETURN;
         end else if (pick < 97) begin
            r.cmd = CMD_REWIND;
         end else if (pick < 99) begin
            r.cmd = CMD_SET_ORIGIN;
         end else begin
            r.cmd = CMD_UNUSED;
         end
         return r;
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] value);
      begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
         csr_valid <= 1'b0;
      end
   endtask

   // wait until nothing is in flight, then let commands without output finish
   task automatic drain_and_settle();
      begin
         do @(posedge clock);
         while (cmd_backlog.size() != 0 || req_valid || expected_patterns.size() != 0);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, both directions, stop, targets, angles, origin
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_DIR,    DIR_CCW,  32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RETURN,     DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RETURN,     DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_DIR,    2'd3,     32'hFFFF_FFFF,  16'hFFFF);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_DIR,    DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_STEPS,  DIR_CW,   32'd2,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_STEPS,  DIR_CW,   32'h8000_0000,  16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_ANGLE,  DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_ANGLE,  DIR_CW,   32'd0,          16'h7FFF);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_ANGLE,  DIR_CW,   32'd0,          16'h8000);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_REWIND,     DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_SET_STEPS,  DIR_CW,   32'h7FFF_FFFF,  16'd0);
      queue_req(CMD_SET_ORIGIN, DIR_CW,   32'd0,          16'd0);
      queue_req(CMD_UNUSED,     DIR_STOP, 32'd0,          16'd0);
      queue_req(CMD_RUN,        DIR_CW,   32'd0,          16'd0);
      drain_and_settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_STEPS_PER_TURN, 16'd1);
               write_csr(CSR_PHASE_HOLD, 16'd0);
            end
            1: begin
               write_csr(CSR_STEPS_PER_TURN, 16'hFFFF);
               write_csr(CSR_PHASE_HOLD, 16'hFFFF);
            end
            2: begin
               write_csr(CSR_STEPS_PER_TURN, 16'd0);
               write_csr(CSR_PHASE_HOLD, 16'($urandom));
            end
            default: begin
               write_csr(CSR_STEPS_PER_TURN, 16'd360);
               write_csr(CSR_PHASE_HOLD, 16'($urandom));
            end
         endcase
         @(posedge clock);
         send_idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 37 : 0;
         recv_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 37 : 0;
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            cmd_backlog.push_back(random_req());
         // receiver backs off while commands keep coming, so the block fills up
         if (phase == 0)
            hold_off_arm = 1'b1;
         drain_and_settle();
      end

      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
